### design/lrd_pkg.sv
// Package for the log record deframer: result record type, status and kind codes,
// parse phases and the CRC-32 byte lookup table.
// No dependencies.
package lrd_pkg;

  localparam logic [31:0] CRC_POLY       = 32'hEDB88320;
  localparam logic [31:0] CRC_ALL_ONES   = 32'hFFFFFFFF;
  localparam logic [31:0] MAX_LEN_RESET  = 32'd10485760;

  // byte_kind codes
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_KEY   = 2'd1;
  localparam logic [1:0] KIND_VALUE = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_CRC_ERR   = 3'd1;
  localparam logic [2:0] ST_LEN_ERR   = 3'd2;
  localparam logic [2:0] ST_TRUNCATED = 3'd3;
  localparam logic [2:0] ST_CLEAN_END = 3'd4;

  typedef enum logic [5:0] {
    PH_CRC  = 6'b000001,
    PH_TYPE = 6'b000010,
    PH_KLEN = 6'b000100,
    PH_VLEN = 6'b001000,
    PH_KEY  = 6'b010000,
    PH_VAL  = 6'b100000
  } lrd_phase_t;

  typedef struct packed {
    logic [1:0]  byte_kind;
    logic [7:0]  payload_byte;
    logic        record_done;
    logic [2:0]  status;
    logic [7:0]  record_type;
    logic [31:0] key_length;
    logic [31:0] value_length;
    logic [31:0] sequence_number;
  } lrd_result_t;

  typedef logic [31:0] crc_tab_t [256];

  function automatic crc_tab_t crc_gen_table();
    crc_tab_t    tab;
    logic [31:0] c;
    for (int i = 0; i < 256; i++) begin
      c = 32'(i);
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      tab[i] = c;
    end
    return tab;
  endfunction

  localparam crc_tab_t CRC_TABLE = crc_gen_table();

  // One reflected CRC-32 byte step through the lookup table.
  function automatic logic [31:0] crc_step(logic [31:0] crc, logic [7:0] b);
    logic [7:0] idx;
    idx = crc[7:0] ^ b;
    return (crc >> 8) ^ CRC_TABLE[idx];
  endfunction

endpackage

### design/log_record_deframer_crc32_top.sv
// Top level of the log record deframer with CRC-32 check.
// Depends on lrd_pkg, lrd_parser and lrd_out_buf.
//
// Input channel (in_valid / in_stall): one log byte per transfer, or an
// end-of-log marker when in_end_of_log is high (the byte is then ignored).
// Output channel (out_valid / out_stall): at most one result per input
// transfer - a key or value byte, a record close with its status, or an
// end-of-log / error report. Bytes seen while halted give no result; header
// bytes give one only on a length error or an empty record's close.
// Config channel (cfg_valid / cfg_ready): writes max_field_length; always
// ready. Write it only while the block is idle.
// Results are registered (output register, or skid entry on a stall). Throughput
// one byte per cycle while in_stall is low, set by the running CRC-32 (a table
// lookup and xor each byte) and the length compares on the last value-length byte.
// Reset: synchronous, active low. The parser returns to the stored-CRC phase,
// the sequence count and halt clear, and max_field_length returns to 10 MiB.
// Stall: the output register holds its result and one more result lands in
// the skid entry; then in_stall rises and holds the input until the output
// register frees up.
module log_record_deframer_crc32_top
  import lrd_pkg::*;
#(
  parameter int SEQUENCE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_log_byte,
  input  logic        in_end_of_log,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_byte_kind,
  output logic [7:0]  out_payload_byte,
  output logic        out_record_done,
  output logic [2:0]  out_status,
  output logic [7:0]  out_record_type,
  output logic [31:0] out_key_length,
  output logic [31:0] out_value_length,
  output logic [31:0] out_sequence_number,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic        cfg_write;
  logic [31:0] max_len_r;
  logic        accept;
  logic        res_valid;
  lrd_result_t res;
  lrd_result_t out_data;
  logic        buf_full;

  // Config register: always ready, takes the write data on each transfer.
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_write) begin
      max_len_r <= cfg_data;
    end
  end

  // Accept a byte whenever the skid entry is free.
  assign in_stall = buf_full;
  assign accept   = in_valid && !in_stall;

  lrd_parser #(
    .SEQUENCE_BITS(SEQUENCE_BITS)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (accept),
    .log_byte   (in_log_byte),
    .end_of_log (in_end_of_log),
    .max_len    (max_len_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  lrd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Fan the result record out onto its ports.
  assign out_byte_kind       = out_data.byte_kind;
  assign out_payload_byte    = out_data.payload_byte;
  assign out_record_done     = out_data.record_done;
  assign out_status          = out_data.status;
  assign out_record_type     = out_data.record_type;
  assign out_key_length      = out_data.key_length;
  assign out_value_length    = out_data.value_length;
  assign out_sequence_number = out_data.sequence_number;

endmodule

### design/lrd_parser.sv
// Record parser: phase register, byte counter, header capture, running CRC
// and sequence counter; produces at most one result per accepted byte.
// Depends on lrd_pkg.
module lrd_parser
  import lrd_pkg::*;
#(
  parameter int SEQUENCE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_en,
  input  logic [7:0]  log_byte,
  input  logic        end_of_log,
  input  logic [31:0] max_len,
  output logic        res_valid,
  output lrd_result_t res
);

  lrd_phase_t               phase_r, phase_nxt;
  logic [31:0]              cnt_r, cnt_nxt;
  logic [31:0]              stored_r, stored_nxt;
  logic [31:0]              crc_r, crc_nxt;
  logic [31:0]              klen_r, klen_nxt;
  logic [31:0]              vlen_r, vlen_nxt;
  logic [7:0]               type_r, type_nxt;
  logic [SEQUENCE_BITS-1:0] seq_r, seq_nxt;
  logic                     halted_r, halted_nxt;

  logic [31:0]              crc_upd;
  logic [SEQUENCE_BITS-1:0] seq_inc;
  logic [SEQUENCE_BITS+31:0] seq_ext;
  logic [4:0]               lane;
  logic                     finish;
  logic                     restart;
  logic                     clean;

  assign crc_upd = crc_step(crc_r, log_byte);
  assign seq_inc = (seq_r == '1) ? seq_r : seq_r + 1'b1;
  assign seq_ext = {32'd0, seq_inc};
  assign lane    = {cnt_r[1:0], 3'b000};
  assign clean   = halted_r || ((phase_r == PH_CRC) && (cnt_r == 32'd0));

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    stored_nxt = stored_r;
    crc_nxt    = crc_r;
    klen_nxt   = klen_r;
    vlen_nxt   = vlen_r;
    type_nxt   = type_r;
    seq_nxt    = seq_r;
    halted_nxt = halted_r;
    res_valid  = 1'b0;
    res        = '0;
    finish     = 1'b0;
    restart    = 1'b0;

    if (step_en) begin
      if (end_of_log) begin
        res_valid   = 1'b1;
        res.record_done = 1'b1;
        res.status  = clean ? ST_CLEAN_END : ST_TRUNCATED;
        halted_nxt  = 1'b0;
        seq_nxt     = '0;
        restart     = 1'b1;
      end else if (!halted_r) begin
        case (phase_r)
          PH_CRC: begin
            stored_nxt[lane +: 8] = log_byte;
            if (cnt_r[1:0] == 2'd3) begin
              cnt_nxt   = 32'd0;
              phase_nxt = PH_TYPE;
            end else begin
              cnt_nxt = cnt_r + 32'd1;
            end
          end
          PH_TYPE: begin
            type_nxt  = log_byte;
            crc_nxt   = crc_upd;
            phase_nxt = PH_KLEN;
          end
          PH_KLEN: begin
            klen_nxt[lane +: 8] = log_byte;
            crc_nxt = crc_upd;
            if (cnt_r[1:0] == 2'd3) begin
              cnt_nxt   = 32'd0;
              phase_nxt = PH_VLEN;
            end else begin
              cnt_nxt = cnt_r + 32'd1;
            end
          end
          PH_VLEN: begin
            vlen_nxt[lane +: 8] = log_byte;
            crc_nxt = crc_upd;
            if (cnt_r[1:0] != 2'd3) begin
              cnt_nxt = cnt_r + 32'd1;
            end else begin
              cnt_nxt = 32'd0;
              if ((klen_r > max_len) || (vlen_nxt > max_len)) begin
                halted_nxt      = 1'b1;
                res_valid       = 1'b1;
                res.record_done = 1'b1;
                res.status      = ST_LEN_ERR;
              end else if (klen_r != 32'd0) begin
                phase_nxt = PH_KEY;
                cnt_nxt   = klen_r;
              end else if (vlen_nxt != 32'd0) begin
                phase_nxt = PH_VAL;
                cnt_nxt   = vlen_nxt;
              end else begin
                finish = 1'b1;
              end
            end
          end
          PH_KEY: begin
            crc_nxt          = crc_upd;
            res_valid        = 1'b1;
            res.byte_kind    = KIND_KEY;
            res.payload_byte = log_byte;
            cnt_nxt          = cnt_r - 32'd1;
            if (cnt_r == 32'd1) begin
              if (vlen_r != 32'd0) begin
                phase_nxt = PH_VAL;
                cnt_nxt   = vlen_r;
              end else begin
                finish = 1'b1;
              end
            end
          end
          PH_VAL: begin
            crc_nxt          = crc_upd;
            res_valid        = 1'b1;
            res.byte_kind    = KIND_VALUE;
            res.payload_byte = log_byte;
            cnt_nxt          = cnt_r - 32'd1;
            if (cnt_r == 32'd1) begin
              finish = 1'b1;
            end
          end
          default: begin
            phase_nxt = PH_CRC;
          end
        endcase

        // Close the record: compare the finished CRC against the stored one.
        if (finish) begin
          res_valid       = 1'b1;
          res.record_done = 1'b1;
          restart         = 1'b1;
          if ((crc_upd ^ CRC_ALL_ONES) == stored_r) begin
            res.status          = ST_OK;
            seq_nxt             = seq_inc;
            res.sequence_number = seq_ext[31:0];
          end else begin
            res.status = ST_CRC_ERR;
            halted_nxt = 1'b1;
          end
        end

        if (res_valid) begin
          res.record_type  = type_nxt;
          res.key_length   = klen_nxt;
          res.value_length = vlen_nxt;
        end
      end

      if (restart) begin
        phase_nxt  = PH_CRC;
        cnt_nxt    = 32'd0;
        stored_nxt = 32'd0;
        crc_nxt    = CRC_ALL_ONES;
        klen_nxt   = 32'd0;
        vlen_nxt   = 32'd0;
        type_nxt   = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_CRC;
      cnt_r    <= 32'd0;
      stored_r <= 32'd0;
      crc_r    <= CRC_ALL_ONES;
      klen_r   <= 32'd0;
      vlen_r   <= 32'd0;
      type_r   <= 8'd0;
      seq_r    <= '0;
      halted_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      stored_r <= stored_nxt;
      crc_r    <= crc_nxt;
      klen_r   <= klen_nxt;
      vlen_r   <= vlen_nxt;
      type_r   <= type_nxt;
      seq_r    <= seq_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

### design/lrd_out_buf.sv
// Result output register with one skid entry behind it.
// Depends on lrd_pkg.
module lrd_out_buf
  import lrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  lrd_result_t push_data,
  output logic        full,
  output logic        out_valid,
  input  logic        out_stall,
  output lrd_result_t out_data
);

  logic        main_valid_r, main_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  lrd_result_t main_r, main_nxt;
  lrd_result_t skid_r, skid_nxt;
  logic        main_free;

  assign main_free = !main_valid_r || !out_stall;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (main_free) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        main_valid_nxt = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        main_nxt       = push_data;
        main_valid_nxt = push;
      end
    end else if (push) begin
      skid_nxt       = push_data;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

endmodule

### design/lrd_checker.sv
// Port-level checker for the log record deframer, bound to the top level.
// Depends on lrd_pkg.
module lrd_checker
  import lrd_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_byte_kind,
  input logic [7:0]  out_payload_byte,
  input logic        out_record_done,
  input logic [2:0]  out_status,
  input logic [31:0] out_sequence_number
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_payload_byte)
      && $stable(out_status) && $stable(out_sequence_number))
    else $error("stalled result changed");

  // Every result carries a byte or closes something.
  a_no_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_byte_kind != KIND_NONE) || out_record_done)
    else $error("empty result");

  // Status only on a closing result.
  a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_record_done |-> out_status == ST_OK)
    else $error("status without record close");

  // A sequence number only on a passing record close.
  a_seq_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_sequence_number != 32'd0) |->
      out_record_done && (out_status == ST_OK))
    else $error("sequence number on non-passing result");

endmodule

bind log_record_deframer_crc32_top lrd_checker u_lrd_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_byte_kind       (out_byte_kind),
  .out_payload_byte    (out_payload_byte),
  .out_record_done     (out_record_done),
  .out_status          (out_status),
  .out_sequence_number (out_sequence_number)
);
